@@ rtl/wfc_pkg.sv @@
package wfc_pkg;

  // Default table geometry.
  localparam int unsigned DEF_TABLE_WORDS = 32;
  localparam int unsigned DEF_WORD_CHARS  = 64;

  // Character constants.
  localparam logic [7:0] APOSTROPHE = 8'h27;

  // Request commands.
  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds.
  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LONG = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Operation broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       append;   // byte is stored at the current position
    logic       endw;     // word ends and is looked up
    logic       clr;      // end of text, match flags return to idle
    logic       any_hit;  // some cell matched the ending word
    logic [7:0] ch;       // byte being appended
  } wfc_ctl_t;

  // Lookup result handed along the row of cells.
  typedef struct packed {
    logic        hit;
    logic [7:0]  slot;
    logic [15:0] count;
  } wfc_link_t;

endpackage

@@ rtl/wfc_cell.sv @@
module wfc_cell
  import wfc_pkg::*;
#(
  parameter int unsigned TABLE_WORDS = DEF_TABLE_WORDS,
  parameter int unsigned WORD_CHARS  = DEF_WORD_CHARS,
  parameter int unsigned INDEX       = 0,
  localparam int unsigned LW = $clog2(WORD_CHARS + 1),
  localparam int unsigned DW = $clog2(TABLE_WORDS + 1),
  localparam int unsigned AW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wfc_ctl_t      ctl_i,
  input  logic [LW-1:0] cur_len_i,
  input  logic [LW-1:0] rd_addr_i,
  input  logic [DW-1:0] distinct_i,
  input  wfc_link_t     link_i,
  output wfc_link_t     link_o,
  output logic          hit_o
);

  logic [7:0]    mem [WORD_CHARS];
  logic [7:0]    rd_q;
  logic [LW-1:0] len_q;
  logic [15:0]   tally_q;
  logic          mt_q, mt_d;
  logic          valid, free, insert;
  logic [15:0]   next_count;

  // This cell holds a word when its index is below the fill count; the first
  // empty cell collects the bytes of the word being built.
  assign valid  = DW'(INDEX) < distinct_i;
  assign free   = DW'(INDEX) == distinct_i;
  assign insert = ctl_i.endw && !ctl_i.any_hit && free;

  // Word text store, read one position ahead of the arriving byte.
  always_ff @(posedge clk_i) begin
    if (ctl_i.append && free) begin
      mem[cur_len_i[AW-1:0]] <= ctl_i.ch;
    end
    rd_q <= mem[rd_addr_i[AW-1:0]];
  end

  // Running match flag for the word being built.
  always_comb begin
    mt_d = mt_q;
    if (ctl_i.endw || ctl_i.clr) begin
      mt_d = 1'b1;
    end else if (ctl_i.append) begin
      mt_d = mt_q && (rd_q == ctl_i.ch);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mt_q <= 1'b1;
    end else begin
      mt_q <= mt_d;
    end
  end

  assign hit_o      = valid && mt_q && (len_q == cur_len_i);
  assign next_count = (tally_q == COUNT_MAX) ? tally_q : tally_q + 16'd1;

  // Length and tally of the stored word.
  always_ff @(posedge clk_i) begin
    if (insert) begin
      len_q   <= cur_len_i;
      tally_q <= 16'd1;
    end else if (ctl_i.endw && hit_o) begin
      tally_q <= next_count;
    end
  end

  // Pass the lookup result on to the next cell.
  always_comb begin
    link_o = link_i;
    if (hit_o) begin
      link_o.hit   = 1'b1;
      link_o.slot  = 8'(INDEX);
      link_o.count = next_count;
    end
  end

endmodule

@@ rtl/word_frequency_counter_core.sv @@
// Word frequency counter.
// Input channel: in_valid_i / in_stall_o with cmd_i and char_code_i. A text
// request carries one byte; an end-of-text request flushes the last word,
// reports the status and the number of distinct words, and empties the table.
// Output channel: out_valid_o / out_stall_i. A word result appears when a word
// ends with no error held, unless it is new and the table is full; an end of
// text gives at most one word result followed by the summary, with last_o set.
// Each request is worked in S_FIRST, and also in S_SECOND when a pending
// apostrophe is resolved or an end of text also flushes a word; the request
// is held while the block works, so a new byte waits until the last is done.
// A result is registered and appears on the output in the cycle after its work.
// Lookup is done by a row of cells, one per table entry, each comparing the
// arriving bytes with its stored word as they stream in; at the word end the
// lookup is combinational along the row, so no further scan is needed.
// While a result waits under stall, work that would give another result waits.
// Reset empties the table and clears all word state; no clearing pass is run.
module word_frequency_counter_core
  import wfc_pkg::*;
#(
  parameter int unsigned TABLE_WORDS = DEF_TABLE_WORDS,
  parameter int unsigned WORD_CHARS  = DEF_WORD_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [4:0]  slot_o,
  output logic [15:0] word_count_o,
  output logic        is_new_o,
  output logic [1:0]  status_o,
  output logic [5:0]  distinct_o,
  output logic        last_o
);

  localparam int unsigned LW = $clog2(WORD_CHARS + 1);
  localparam int unsigned DW = $clog2(TABLE_WORDS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FIRST  = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;

  logic [1:0]    st_q, st_d;
  logic          cmd_q;
  logic [7:0]    ch_q;
  logic [LW-1:0] len_q, len_d;
  logic [DW-1:0] dist_q, dist_d;
  logic          inside_q, inside_d;
  logic          ap_q, ap_d;
  logic          prev_q, prev_d;
  logic [1:0]    err_q, err_d;

  logic          out_v_q;
  logic          kind_q, new_q, last_q;
  logic [4:0]    slot_q;
  logic [15:0]   count_q;
  logic [1:0]    status_q;
  logic [5:0]    dist_out_q;

  logic [7:0]    lc;
  logic          alpha, digit, out_free, go;
  logic          op_app, op_end, op_sum, end_last;
  logic [7:0]    app_ch;
  logic          app_ok, full;
  wfc_ctl_t      ctl;
  wfc_link_t     link [TABLE_WORDS+1];
  logic [TABLE_WORDS-1:0] hit_vec;
  logic [7:0]    new_slot;

  // Character class of the held byte.
  assign lc    = (ch_q >= 8'h41 && ch_q <= 8'h5A) ? (ch_q | 8'h20) : ch_q;
  assign alpha = lc >= 8'h61 && lc <= 8'h7A;
  assign digit = lc >= 8'h30 && lc <= 8'h39;

  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = st_q != S_IDLE;

  // Choose the operation for this cycle.
  always_comb begin
    op_app   = 1'b0;
    op_end   = 1'b0;
    op_sum   = 1'b0;
    end_last = 1'b1;
    app_ch   = lc;
    ap_d     = ap_q;
    prev_d   = prev_q;
    st_d     = st_q;
    if (st_q != S_IDLE) begin
      st_d = S_IDLE;
      if (cmd_q == CMD_END) begin
        if (st_q == S_FIRST && err_q == ST_OK && inside_q) begin
          op_end   = 1'b1;
          end_last = 1'b0;
          st_d     = S_SECOND;
        end else begin
          op_sum = 1'b1;
        end
      end else if (err_q == ST_OK) begin
        if (ap_q && st_q == S_FIRST) begin
          // Resolve the apostrophe held back from the previous byte.
          ap_d = 1'b0;
          st_d = S_SECOND;
          if (alpha) begin
            op_app = 1'b1;
            app_ch = APOSTROPHE;
          end else begin
            op_end = 1'b1;
          end
        end else begin
          prev_d = alpha;
          if (alpha || digit) begin
            op_app = 1'b1;
          end else if (lc == APOSTROPHE && prev_q && inside_q) begin
            ap_d = 1'b1;
          end else if (inside_q) begin
            op_end = 1'b1;
          end
        end
      end
    end
  end

  assign go     = !(op_end || op_sum) || out_free;
  assign app_ok = op_app && (len_q < LW'(WORD_CHARS));
  assign full   = dist_q >= DW'(TABLE_WORDS);

  // Next word state.
  always_comb begin
    len_d    = len_q;
    dist_d   = dist_q;
    inside_d = inside_q;
    err_d    = err_q;
    if (go) begin
      if (op_app) begin
        if (app_ok) begin
          len_d    = len_q + LW'(1);
          inside_d = 1'b1;
        end else begin
          err_d = ST_LONG;
        end
      end
      if (op_end) begin
        len_d    = '0;
        inside_d = 1'b0;
        if (!link[TABLE_WORDS].hit) begin
          if (full) begin
            err_d = ST_FULL;
          end else begin
            dist_d = dist_q + DW'(1);
          end
        end
      end
      if (op_sum) begin
        len_d    = '0;
        dist_d   = '0;
        inside_d = 1'b0;
        err_d    = ST_OK;
      end
    end
  end

  always_comb begin
    ctl.append  = go && app_ok;
    ctl.endw    = go && op_end;
    ctl.clr     = go && op_sum;
    ctl.any_hit = link[TABLE_WORDS].hit;
    ctl.ch      = app_ch;
  end

  // Row of match cells; the lookup result runs along the row.
  assign link[0] = '0;
  for (genvar i = 0; i < TABLE_WORDS; i++) begin : g_cell
    wfc_cell #(
      .TABLE_WORDS(TABLE_WORDS),
      .WORD_CHARS (WORD_CHARS),
      .INDEX      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .cur_len_i (len_q),
      .rd_addr_i (len_d),
      .distinct_i(dist_q),
      .link_i    (link[i]),
      .link_o    (link[i+1]),
      .hit_o     (hit_vec[i])
    );
  end

  // Sequencer and word state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      len_q    <= '0;
      dist_q   <= '0;
      inside_q <= 1'b0;
      ap_q     <= 1'b0;
      prev_q   <= 1'b0;
      err_q    <= ST_OK;
    end else if (st_q == S_IDLE) begin
      if (in_valid_i) begin
        st_q <= S_FIRST;
      end
    end else if (go) begin
      st_q     <= st_d;
      len_q    <= len_d;
      dist_q   <= dist_d;
      inside_q <= inside_d;
      ap_q     <= (op_end || op_sum) ? 1'b0 : ap_d;
      prev_q   <= op_sum ? 1'b0 : prev_d;
      err_q    <= err_d;
    end
  end

  // Held request.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= cmd_i;
      ch_q  <= char_code_i;
    end
  end

  // Output register.
  assign new_slot = 8'(dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (go && (op_sum || (op_end && (link[TABLE_WORDS].hit || !full)))) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && op_sum) begin
      kind_q     <= KIND_SUMMARY;
      slot_q     <= '0;
      count_q    <= '0;
      new_q      <= 1'b0;
      status_q   <= err_q;
      dist_out_q <= 6'(dist_q);
      last_q     <= 1'b1;
    end else if (go && op_end) begin
      kind_q   <= KIND_WORD;
      status_q <= ST_OK;
      last_q   <= end_last;
      if (link[TABLE_WORDS].hit) begin
        slot_q     <= link[TABLE_WORDS].slot[4:0];
        count_q    <= link[TABLE_WORDS].count;
        new_q      <= 1'b0;
        dist_out_q <= 6'(dist_q);
      end else begin
        slot_q     <= new_slot[4:0];
        count_q    <= 16'd1;
        new_q      <= 1'b1;
        dist_out_q <= 6'(dist_d);
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign kind_o       = kind_q;
  assign slot_o       = slot_q;
  assign word_count_o = count_q;
  assign is_new_o     = new_q;
  assign status_o     = status_q;
  assign distinct_o   = dist_out_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q <= DW'(TABLE_WORDS))
    else $error("fill count beyond table size");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("word matched in more than one cell");

  a_inside_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> len_q != '0)
    else $error("inside a word with no bytes");

  a_err_no_ap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK |-> !ap_q)
    else $error("apostrophe pending after an error");
`endif

endmodule
